// ===== sv/gbcg_pkg.sv =====
`default_nettype none

package gbcg_pkg;

    localparam int SLOTS       = 128;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CNT_W  = $clog2(SLOTS + 1);
    localparam int CODES       = 256;
    localparam int CODE_W      = 8;
    localparam int ROW_W       = 4;
    localparam int ROWS        = 16;
    localparam int GLYPH_DEPTH = SLOTS * ROWS;
    localparam int GADDR_W     = SLOT_W + ROW_W;
    localparam int BITS_W      = 16;
    localparam int POS_W       = 12;
    localparam int ROWY_W      = 13;
    localparam int MWIDTH_W    = 5;
    localparam int COLOR_W     = 8;
    localparam int FMT_W       = 2;

    localparam logic [FMT_W-1:0] FMT_8X8       = 2'd0;
    localparam logic [FMT_W-1:0] FMT_8X16      = 2'd1;
    localparam logic [FMT_W-1:0] FMT_16X16     = 2'd2;
    localparam logic [FMT_W-1:0] FMT_16X16_ALT = 2'd3;

    localparam logic CMD_DEFINE = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    localparam logic [ROW_W-1:0] LAST_ROW_SHORT = 4'd7;
    localparam logic [ROW_W-1:0] LAST_ROW_TALL  = 4'd15;

    localparam logic [MWIDTH_W-1:0] MWIDTH_NARROW = 5'd8;
    localparam logic [MWIDTH_W-1:0] MWIDTH_WIDE   = 5'd16;

    typedef struct packed {
        logic load;
        logic alloc;
        logic write_one;
        logic sweep;
        logic issue;
    } gbcg_cmd_t;

    typedef struct packed {
        logic is_draw;
        logic row_ok;
        logic mapped;
        logic bank_full;
        logic cnt_done;
        logic issue_ready;
    } gbcg_sts_t;

endpackage

`default_nettype wire

// ===== sv/gbcg_datapath.sv =====
`default_nettype none

module gbcg_datapath
    import gbcg_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [FMT_W-1:0]        cfg_wdata,
    input  wire logic                    in_cmd,
    input  wire logic [CODE_W-1:0]       in_char_code,
    input  wire logic [ROW_W-1:0]        in_row_index,
    input  wire logic [BITS_W-1:0]       in_row_bits,
    input  wire logic [POS_W-1:0]        in_x_pos,
    input  wire logic [POS_W-1:0]        in_y_pos,
    input  wire logic [COLOR_W-1:0]      in_color,
    input  wire gbcg_cmd_t               cmd,
    output gbcg_sts_t                    sts,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [POS_W-1:0]             out_x,
    output logic [ROWY_W-1:0]            out_row_y,
    output logic [BITS_W-1:0]            out_pixel_mask,
    output logic [MWIDTH_W-1:0]          out_mask_width,
    output logic [COLOR_W-1:0]           out_color,
    output logic                         out_last
);

    logic [FMT_W-1:0]      glyph_size_reg;

    logic                  cmd_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [BITS_W-1:0]     bits_reg;
    logic [POS_W-1:0]      x_reg;
    logic [POS_W-1:0]      y_reg;
    logic [COLOR_W-1:0]    color_reg;

    logic [CODES-1:0]      code_valid_reg;
    logic [SLOT_W-1:0]     slot_mem [0:CODES-1];
    logic                  mapped_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_CNT_W-1:0] slots_used_reg;
    logic [ROW_W-1:0]      cnt_reg;

    logic [BITS_W-1:0]     glyph_mem [0:GLYPH_DEPTH-1];

    logic                  rd_valid_reg;
    logic [BITS_W-1:0]     rd_data_reg;
    logic [POS_W-1:0]      rd_x_reg;
    logic [ROWY_W-1:0]     rd_row_y_reg;
    logic [COLOR_W-1:0]    rd_color_reg;
    logic                  rd_wide_reg;
    logic                  rd_last_reg;

    logic                  out_valid_reg;
    logic [POS_W-1:0]      out_x_reg;
    logic [ROWY_W-1:0]     out_row_y_reg;
    logic [BITS_W-1:0]     out_mask_reg;
    logic [MWIDTH_W-1:0]   out_width_reg;
    logic [COLOR_W-1:0]    out_color_reg;
    logic                  out_last_reg;

    logic                  tall;
    logic                  wide;
    logic [BITS_W-1:0]     bits_masked;
    logic [ROW_W-1:0]      last_cnt;
    logic                  out_load;
    logic [GADDR_W-1:0]    wr_addr;
    logic [BITS_W-1:0]     wr_data;
    logic [ROWY_W-1:0]     row_y_next;

    assign tall        = (glyph_size_reg != FMT_8X8);
    assign wide        = (glyph_size_reg != FMT_8X8) && (glyph_size_reg != FMT_8X16);
    assign bits_masked = wide ? bits_reg : {8'h00, bits_reg[7:0]};
    assign last_cnt    = (cmd_reg == CMD_DRAW && !tall) ? LAST_ROW_SHORT : LAST_ROW_TALL;
    assign out_load    = rd_valid_reg && (!out_valid_reg || out_ready);
    assign row_y_next  = {y_reg[POS_W-1], y_reg} + {{(ROWY_W-ROW_W){1'b0}}, cnt_reg};

    always_comb begin
        if (cmd.sweep) begin
            wr_addr = {slot_reg, cnt_reg};
            wr_data = (cnt_reg == row_reg) ? bits_masked : '0;
        end else begin
            wr_addr = {slot_reg, row_reg};
            wr_data = bits_masked;
        end
    end

    always_comb begin
        sts.is_draw     = (cmd_reg == CMD_DRAW);
        sts.row_ok      = tall || !row_reg[ROW_W-1];
        sts.mapped      = mapped_reg;
        sts.bank_full   = (slots_used_reg == SLOT_CNT_W'(SLOTS));
        sts.cnt_done    = (cnt_reg == last_cnt);
        sts.issue_ready = !rd_valid_reg || out_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_size_reg <= FMT_8X8;
        end else if (cfg_we) begin
            glyph_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_cmd;
            code_reg  <= in_char_code;
            row_reg   <= in_row_index;
            bits_reg  <= in_row_bits;
            x_reg     <= in_x_pos;
            y_reg     <= in_y_pos;
            color_reg <= in_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_valid_reg <= '0;
            slots_used_reg <= '0;
        end else if (cmd.alloc) begin
            code_valid_reg[code_reg] <= 1'b1;
            slots_used_reg           <= slots_used_reg + SLOT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            slot_mem[code_reg] <= slots_used_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            slot_reg   <= slot_mem[in_char_code];
            mapped_reg <= code_valid_reg[in_char_code];
        end else if (cmd.alloc) begin
            slot_reg   <= slots_used_reg[SLOT_W-1:0];
            mapped_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.sweep || cmd.issue) begin
            cnt_reg <= cnt_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_one || cmd.sweep) begin
            glyph_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg <= glyph_mem[{slot_reg, cnt_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (cmd.issue) begin
            rd_valid_reg <= 1'b1;
        end else if (out_load) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_x_reg     <= x_reg;
            rd_row_y_reg <= row_y_next;
            rd_color_reg <= color_reg;
            rd_wide_reg  <= wide;
            rd_last_reg  <= (cnt_reg == last_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg     <= rd_x_reg;
            out_row_y_reg <= rd_row_y_reg;
            out_mask_reg  <= rd_wide_reg ? rd_data_reg : {8'h00, rd_data_reg[7:0]};
            out_width_reg <= rd_wide_reg ? MWIDTH_WIDE : MWIDTH_NARROW;
            out_color_reg <= rd_color_reg;
            out_last_reg  <= rd_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_x          = out_x_reg;
    assign out_row_y      = out_row_y_reg;
    assign out_pixel_mask = out_mask_reg;
    assign out_mask_width = out_width_reg;
    assign out_color      = out_color_reg;
    assign out_last       = out_last_reg;

    a_slots_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slots_used_reg <= SLOT_CNT_W'(SLOTS))
        else $error("slot count beyond bank size");

    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |=> slots_used_reg == $past(slots_used_reg) + SLOT_CNT_W'(1))
        else $error("allocation did not advance slot count");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> sts.issue_ready)
        else $error("row read issued while read stage is blocked");

    a_write_or_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.sweep && cmd.issue) && !(cmd.alloc && cmd.load))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== sv/gbcg_controller.sv =====
`default_nettype none

module gbcg_controller
    import gbcg_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire gbcg_sts_t sts,
    output gbcg_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLEAR,
        ST_DRAW
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_IDLE;
                if (sts.is_draw) begin
                    if (sts.mapped) begin
                        state_next = ST_DRAW;
                    end
                end else if (sts.row_ok) begin
                    if (sts.mapped) begin
                        cmd.write_one = 1'b1;
                    end else if (!sts.bank_full) begin
                        cmd.alloc  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (sts.cnt_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW: begin
                if (sts.issue_ready) begin
                    cmd.issue = 1'b1;
                    if (sts.cnt_done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_alloc_then_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |=> state_reg == ST_CLEAR)
        else $error("allocation not followed by slot clear");

    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE && in_valid)
        else $error("item taken outside idle");

    a_clear_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !sts.cnt_done) |=> state_reg == ST_CLEAR)
        else $error("slot clear cut short");

endmodule

`default_nettype wire

// ===== sv/glyph_bank_char_generator_top.sv =====
`default_nettype none

// Glyph bank character generator.
// Input channel s_*: one item per define or draw; s_tuser is the command
// (0 = define one glyph row, 1 = draw). Result channel m_*: one item per
// glyph row of a draw, top row first, m_tlast on the final row.
// cfg_we/cfg_wdata write the glyph format (0 = 8x8, 1 = 8x16, 2 or 3 = 16x16).
// The format must only be written while no item is in flight; the block does
// not enforce this. Every item passes through code map lookup after acceptance.
// A define of a mapped code writes its one row; the first define of a code
// allocates a slot and writes its 16 rows one per cycle through the single
// glyph memory write port. A draw reads its rows one per cycle from the glyph
// memory while the output does not stall, each through the read stage and the
// output register. A draw of an unmapped code, a define outside the glyph
// height or for a new code with a full bank gives nothing.
// Reset clears the code map, the slot count and the format; slots are
// zeroed as they are handed out, so no clearing pass follows reset.
// When m_tready is low, the output register and one read stage hold and the
// row reads stall; s_tready returns once the last row read has been issued.
module glyph_bank_char_generator_top
    import gbcg_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [FMT_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // char_code[7:0], row_index[11:8], row_bits[27:12], x_pos[39:28],
    // y_pos[51:40], color[59:52], zero[63:60]
    input  wire logic [63:0]      s_tdata,
    // cmd[0]
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // out_x[11:0], row_y[24:12], pixel_mask[40:25], mask_width[45:41],
    // out_color[53:46], zero[55:54]
    output logic [55:0]           m_tdata,
    output logic                  m_tlast
);

    gbcg_cmd_t            cmd;
    gbcg_sts_t            sts;
    logic [POS_W-1:0]     out_x;
    logic [ROWY_W-1:0]    out_row_y;
    logic [BITS_W-1:0]    out_pixel_mask;
    logic [MWIDTH_W-1:0]  out_mask_width;
    logic [COLOR_W-1:0]   out_color;

    gbcg_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbcg_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_cmd         (s_tuser),
        .in_char_code   (s_tdata[7:0]),
        .in_row_index   (s_tdata[11:8]),
        .in_row_bits    (s_tdata[27:12]),
        .in_x_pos       (s_tdata[39:28]),
        .in_y_pos       (s_tdata[51:40]),
        .in_color       (s_tdata[59:52]),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_x          (out_x),
        .out_row_y      (out_row_y),
        .out_pixel_mask (out_pixel_mask),
        .out_mask_width (out_mask_width),
        .out_color      (out_color),
        .out_last       (m_tlast)
    );

    assign m_tdata = {2'b00, out_color, out_mask_width, out_pixel_mask, out_row_y, out_x};

endmodule

`default_nettype wire
